// ===== hdl/slt_pkg.sv =====
package slt_pkg;

	localparam int NKW = 14;

	localparam logic [3:0] M_IDLE    = 4'd0;
	localparam logic [3:0] M_COMMENT = 4'd1;
	localparam logic [3:0] M_IDENT   = 4'd2;
	localparam logic [3:0] M_STRING  = 4'd3;
	localparam logic [3:0] M_ESCAPE  = 4'd4;
	localparam logic [3:0] M_MINUS   = 4'd5;
	localparam logic [3:0] M_ZERO    = 4'd6;
	localparam logic [3:0] M_OCT     = 4'd7;
	localparam logic [3:0] M_DEC     = 4'd8;
	localparam logic [3:0] M_HEX     = 4'd9;
	localparam logic [3:0] M_OPWORD  = 4'd10;

	localparam logic [1:0] REC_TEXT     = 2'd0;
	localparam logic [1:0] REC_COMMENT  = 2'd1;
	localparam logic [1:0] REC_COMPLETE = 2'd2;
	localparam logic [1:0] REC_END      = 2'd3;

	localparam logic [2:0] CLS_IDENT   = 3'd0;
	localparam logic [2:0] CLS_KEYWORD = 3'd1;
	localparam logic [2:0] CLS_NUMBER  = 3'd2;
	localparam logic [2:0] CLS_DQUOTE  = 3'd3;
	localparam logic [2:0] CLS_SQUOTE  = 3'd4;
	localparam logic [2:0] CLS_OPWORD  = 3'd5;

	// keyword text right-justified: first char in the highest used byte
	localparam logic [63:0] KW_TEXT [NKW] = '{
		64'("func"), 64'("const"), 64'("var"), 64'("loop"), 64'("break"),
		64'("continue"), 64'("then"), 64'("else"), 64'("and"), 64'("or"),
		64'("ret"), 64'("pop"), 64'("dup"), 64'("goto")
	};
	localparam logic [3:0] KW_LEN [NKW] = '{
		4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd8, 4'd4, 4'd4, 4'd3, 4'd2, 4'd3, 4'd3, 4'd3, 4'd4
	};

	typedef struct packed {
		logic [1:0]         record_type;
		logic [7:0]         byte_value;
		logic [2:0]         token_class;
		logic [3:0]         keyword_index;
		logic signed [31:0] number_value;
		logic [10:0]        token_length;
		logic               length_overflow;
	} rec_t;

	typedef struct packed {
		logic [1:0] count;
		rec_t [2:0] recs;
	} batch_t;

	function automatic rec_t mk_rec(logic [1:0] rtype, logic [7:0] bval, logic [2:0] cls,
			logic [3:0] kw, logic [31:0] num, logic [10:0] len, logic ovf);
		rec_t r;
		r.record_type     = rtype;
		r.byte_value      = bval;
		r.token_class     = cls;
		r.keyword_index   = kw;
		r.number_value    = num;
		r.token_length    = len;
		r.length_overflow = ovf;
		return r;
	endfunction

	// drop keywords that cannot match with character c at position idx
	function automatic logic [NKW-1:0] kw_step(logic [NKW-1:0] mask, logic beyond,
			logic [2:0] idx, logic [7:0] c);
		logic [NKW-1:0] r;
		logic [5:0]     pos;
		r = mask;
		for (int k = 0; k < NKW; k++) begin
			pos = 6'(KW_LEN[k]) - 6'd1 - 6'(idx);
			if (beyond || {1'b0, idx} >= KW_LEN[k])
				r[k] = 1'b0;
			else if (KW_TEXT[k][{pos[2:0], 3'b000} +: 8] != c)
				r[k] = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== hdl/slt_lexer.sv =====
module slt_lexer #(
	parameter int MAX_TOKEN_LENGTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic [7:0]     chr,
	input  logic           eot,
	output slt_pkg::batch_t batch
);
	import slt_pkg::*;

	localparam int CW = $clog2(MAX_TOKEN_LENGTH + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_TOKEN_LENGTH);

	localparam logic [1:0] CP_TEXT  = 2'd0;
	localparam logic [1:0] CP_IDENT = 2'd1;
	localparam logic [1:0] CP_NUM   = 2'd2;

	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_DQ   = 8'h22;
	localparam logic [7:0] CH_SQ   = 8'h27;
	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_MIN  = 8'h2D;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_0    = 8'h30;

	logic [3:0]     mode_q, m;
	logic           qs_q, qs;
	logic [NKW-1:0] mask_q, mask;
	logic [CW-1:0]  cnt_q, cnt;
	logic [31:0]    acc_q, acc;
	logic           neg_q, neg;
	logic           ovf_q, ovf;

	logic [1:0]  n;
	rec_t [2:0]  recs;
	logic        isend, alpha, digit, octd, hexl, hexu, prt;
	logic [3:0]  dval, hval;
	logic        echo_en, id_push, cp_en, idl_en;
	logic [7:0]  echo_c;
	logic [1:0]  p_en;
	logic [7:0]  p_chr [2];
	logic [1:0]  cp_kind;
	logic [2:0]  cp_cls, qcls;
	logic [7:0]  esc_c;
	logic [7:0]  qchr;
	logic        kw_found;
	logic [3:0]  kw_idx;
	logic [31:0] nval;

	always_comb begin
		isend = eot || (chr == 8'd0);
		alpha = (chr >= 8'h61 && chr <= 8'h7A) || (chr >= 8'h41 && chr <= 8'h5A)
			|| chr == 8'h5F;
		digit = chr >= CH_0 && chr <= 8'h39;
		octd  = chr >= CH_0 && chr <= 8'h37;
		hexl  = chr >= 8'h61 && chr <= 8'h66;
		hexu  = chr >= 8'h41 && chr <= 8'h46;
		prt   = chr > 8'd32 && chr < 8'd128;
		dval  = 4'(chr - CH_0);
		hval  = digit ? dval : (hexl ? 4'(chr - 8'h57) : 4'(chr - 8'h37));
		qcls  = qs_q ? CLS_SQUOTE : CLS_DQUOTE;
		qchr  = qs_q ? CH_SQ : CH_DQ;
		case (chr)
			8'h30:   esc_c = 8'd0;
			8'h6E:   esc_c = 8'd10;
			8'h72:   esc_c = 8'd13;
			8'h74:   esc_c = 8'd9;
			default: esc_c = chr;
		endcase
	end

	always_comb begin
		m = mode_q; qs = qs_q; mask = mask_q; cnt = cnt_q;
		acc = acc_q; neg = neg_q; ovf = ovf_q;
		n = 2'd0;
		recs = '0;
		echo_en = 1'b0; echo_c = 8'd0; id_push = 1'b0;
		p_en = 2'b00; p_chr[0] = 8'd0; p_chr[1] = 8'd0;
		cp_en = 1'b0; cp_kind = CP_TEXT; cp_cls = CLS_IDENT; idl_en = 1'b0;
		kw_found = 1'b0; kw_idx = 4'd0; nval = 32'd0;

		case (mode_q)
			M_COMMENT: begin
				echo_en = 1'b1;
				if (isend) begin
					echo_c = CH_LF;
					idl_en = 1'b1;
				end else if (chr == CH_LF) begin
					echo_c = CH_LF;
					m = M_IDLE;
				end else begin
					echo_c = chr;
				end
			end
			M_IDENT: begin
				if (!isend && (alpha || digit)) begin
					id_push = 1'b1; p_en[0] = 1'b1; p_chr[0] = chr;
				end else begin
					cp_en = 1'b1; cp_kind = CP_IDENT; idl_en = 1'b1;
				end
			end
			M_STRING: begin
				if (isend) begin
					cp_en = 1'b1; cp_cls = qcls; idl_en = 1'b1;
				end else if (chr == qchr) begin
					cp_en = 1'b1; cp_cls = qcls; m = M_IDLE;
				end else if (chr == CH_BSL) begin
					m = M_ESCAPE;
				end else begin
					p_en[0] = 1'b1; p_chr[0] = chr;
				end
			end
			M_ESCAPE: begin
				p_en[0] = 1'b1;
				if (isend) begin
					p_chr[0] = 8'd0;
					cp_en = 1'b1; cp_cls = qcls; idl_en = 1'b1;
				end else begin
					p_chr[0] = esc_c;
					m = M_STRING;
				end
			end
			M_MINUS: begin
				if (!isend && digit) begin
					acc = {28'd0, dval};
					m = (chr == CH_0) ? M_ZERO : M_DEC;
				end else begin
					p_en[0] = 1'b1; p_chr[0] = CH_MIN;
					if (!isend && chr == CH_GT) begin
						p_en[1] = 1'b1; p_chr[1] = CH_GT;
						cp_en = 1'b1; cp_cls = CLS_OPWORD; m = M_IDLE;
					end else if (!isend && prt) begin
						p_en[1] = 1'b1; p_chr[1] = chr; m = M_OPWORD;
					end else begin
						cp_en = 1'b1; cp_cls = CLS_OPWORD; idl_en = 1'b1;
					end
				end
			end
			M_ZERO, M_OCT: begin
				if (mode_q == M_ZERO && !isend && chr == 8'h78) begin
					m = M_HEX;
				end else begin
					m = M_OCT;
					if (!isend && octd)
						acc = {acc_q[28:0], 3'b000} + {28'd0, dval};
					else begin
						cp_en = 1'b1; cp_kind = CP_NUM; idl_en = 1'b1;
					end
				end
			end
			M_DEC: begin
				if (!isend && digit)
					acc = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'd0, dval};
				else begin
					cp_en = 1'b1; cp_kind = CP_NUM; idl_en = 1'b1;
				end
			end
			M_HEX: begin
				if (!isend && (digit || hexl || hexu))
					acc = {acc_q[27:0], 4'b0000} + {28'd0, hval};
				else begin
					cp_en = 1'b1; cp_kind = CP_NUM; idl_en = 1'b1;
				end
			end
			M_OPWORD: begin
				if (!isend && prt) begin
					p_en[0] = 1'b1; p_chr[0] = chr;
				end else begin
					cp_en = 1'b1; cp_cls = CLS_OPWORD; idl_en = 1'b1;
				end
			end
			default: idl_en = 1'b1;
		endcase

		if (echo_en) begin
			recs[n] = mk_rec(REC_COMMENT, echo_c, CLS_IDENT, 4'd0, 32'd0, 11'd0, 1'b0);
			n = n + 2'd1;
		end
		if (id_push)
			mask = kw_step(mask, cnt >= CW'(8), cnt[2:0], chr);
		for (int p = 0; p < 2; p++) begin
			if (p_en[p]) begin
				if (cnt < MAXC) begin
					recs[n] = mk_rec(REC_TEXT, p_chr[p], CLS_IDENT, 4'd0, 32'd0, 11'd0, 1'b0);
					n = n + 2'd1;
					cnt = cnt + CW'(1);
				end else begin
					ovf = 1'b1;
				end
			end
		end
		if (cp_en) begin
			case (cp_kind)
				CP_NUM: begin
					nval = neg ? (32'd0 - acc) : acc;
					recs[n] = mk_rec(REC_COMPLETE, 8'd0, CLS_NUMBER, 4'd0, nval, 11'd0, 1'b0);
				end
				CP_IDENT: begin
					for (int k = NKW - 1; k >= 0; k--) begin
						if (!ovf && mask[k] && cnt == CW'(KW_LEN[k])) begin
							kw_found = 1'b1;
							kw_idx = 4'(k);
						end
					end
					recs[n] = mk_rec(REC_COMPLETE, 8'd0, kw_found ? CLS_KEYWORD : CLS_IDENT,
						kw_idx, 32'd0, 11'(cnt), ovf);
				end
				default:
					recs[n] = mk_rec(REC_COMPLETE, 8'd0, cp_cls, 4'd0, 32'd0, 11'(cnt), ovf);
			endcase
			n = n + 2'd1;
		end
		if (idl_en) begin
			m = M_IDLE;
			if (isend) begin
				recs[n] = mk_rec(REC_END, 8'd0, CLS_IDENT, 4'd0, 32'd0, 11'd0, 1'b0);
				n = n + 2'd1;
				qs = 1'b0;
				mask = '1; cnt = '0; ovf = 1'b0; acc = 32'd0; neg = 1'b0;
			end else if (prt) begin
				mask = '1; cnt = '0; ovf = 1'b0; acc = 32'd0; neg = 1'b0;
				if (chr == CH_HASH) begin
					m = M_COMMENT;
					recs[n] = mk_rec(REC_COMMENT, chr, CLS_IDENT, 4'd0, 32'd0, 11'd0, 1'b0);
					n = n + 2'd1;
				end else if (chr == CH_DQ || chr == CH_SQ) begin
					m = M_STRING;
					qs = (chr == CH_SQ);
				end else if (digit) begin
					acc = {28'd0, dval};
					m = (chr == CH_0) ? M_ZERO : M_DEC;
				end else if (chr == CH_MIN) begin
					neg = 1'b1;
					m = M_MINUS;
				end else begin
					if (alpha) begin
						m = M_IDENT;
						mask = kw_step(mask, 1'b0, 3'd0, chr);
					end else begin
						m = M_OPWORD;
					end
					recs[n] = mk_rec(REC_TEXT, chr, CLS_IDENT, 4'd0, 32'd0, 11'd0, 1'b0);
					n = n + 2'd1;
					cnt = CW'(1);
				end
			end
		end
	end

	assign batch.count = n;
	assign batch.recs  = recs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			qs_q   <= 1'b0;
			mask_q <= '1;
			cnt_q  <= '0;
			acc_q  <= 32'd0;
			neg_q  <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (fire) begin
			mode_q <= m;
			qs_q   <= qs;
			mask_q <= mask;
			cnt_q  <= cnt;
			acc_q  <= acc;
			neg_q  <= neg;
			ovf_q  <= ovf;
		end
	end

endmodule

// ===== hdl/slt_outbuf.sv =====
module slt_outbuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  slt_pkg::batch_t batch,
	output logic            space,
	output logic            valid,
	input  logic            ready,
	output slt_pkg::rec_t   head,
	output logic            last
);
	import slt_pkg::*;

	rec_t [2:0] rec_q;
	logic [1:0] left_q;

	assign valid = left_q != 2'd0;
	assign last  = left_q == 2'd1;
	assign head  = rec_q[0];
	assign space = (left_q == 2'd0) || (left_q == 2'd1 && ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 2'd0;
		end else if (load) begin
			left_q <= batch.count;
		end else if (valid && ready) begin
			left_q <= left_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= batch.recs;
		end else if (valid && ready) begin
			rec_q[0] <= rec_q[1];
			rec_q[1] <= rec_q[2];
		end
	end

endmodule

// ===== hdl/stack_language_tokenizer.sv =====
// channel  dir  tdata                                   tuser        tlast
// s_axis   in   [7:0] char_byte                         -            end_of_text
// m_axis   out  byte, class, keyword, number, length,   record_type  last
//               overflow (packed from bit 0)
// One byte is taken per cycle while it causes at most one record and the output is
// not stalled; a byte that causes more records holds the input while the three-slot
// record buffer drains one transfer per cycle the receiver is ready. The next byte
// enters in the cycle the final record of the previous one leaves. Reset clears the
// lexer state and empties the buffer. Output stalls backpressure the input directly.
module stack_language_tokenizer #(
	parameter int MAX_TOKEN_LENGTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // byte_value, token_class, keyword_index, number_value,
	                              // token_length, length_overflow, zero pad
	output logic [1:0]  m_tuser,  // record_type
	output logic        m_tlast
);
	import slt_pkg::*;

	logic   fire;
	batch_t batch;
	rec_t   head;

	assign fire = s_tvalid && s_tready;

	slt_lexer #(
		.MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
	) u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.chr    (s_tdata),
		.eot    (s_tlast),
		.batch  (batch)
	);

	slt_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire),
		.batch  (batch),
		.space  (s_tready),
		.valid  (m_tvalid),
		.ready  (m_tready),
		.head   (head),
		.last   (m_tlast)
	);

	assign m_tdata = {5'd0, head.length_overflow, head.token_length, head.number_value,
		head.keyword_index, head.token_class, head.byte_value};
	assign m_tuser = head.record_type;

	a_take_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (!m_tvalid || (m_tlast && m_tready)))
		else $error("byte taken while records pending");

	a_end_gives_record: assert property (@(posedge clk) disable iff (!arst_n)
		fire && s_tlast |=> m_tvalid)
		else $error("end of text produced no record");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == REC_END |-> m_tlast)
		else $error("end record not final for its byte");

	a_ovf_on_complete: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[58] |-> m_tuser == REC_COMPLETE)
		else $error("overflow flag outside token complete record");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import slt_pkg::*;

	localparam int TOKEN_CAP    = 1024;
	localparam int HOLD_CYCLES  = 80;
	localparam int RANDOM_ITEMS = 350;
	localparam int MAX_SHOWN    = 10;

	typedef struct packed {
		logic [1:0]  rtype;
		logic [7:0]  bval;
		logic [2:0]  cls;
		logic [3:0]  kw;
		logic [31:0] num;
		logic [10:0] len;
		logic        ovf;
		logic        last;
	} lex_record_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	string kw_words [14] = '{"func", "const", "var", "loop", "break", "continue", "then",
		"else", "and", "or", "ret", "pop", "dup", "goto"};

	// lexer state as the block should hold it
	logic [3:0]  lx_mode;
	logic        lx_single;
	logic [13:0] lx_kw_live;
	int          lx_len;
	logic [31:0] lx_acc;
	logic        lx_neg;
	logic        lx_drop;

	lex_record_t step_recs [$];
	lex_record_t expected_records [$];
	logic [7:0]  src_q [$];

	bit gaps_on = 1'b1;
	bit hold_go = 1'b0;
	bit rx_hold = 1'b0;
	int mismatches;
	int bytes_sent;
	int records_checked;
	int tokens_seen;
	int ends_seen;

	always #5 clk = ~clk;

	stack_language_tokenizer #(.MAX_TOKEN_LENGTH(TOKEN_CAP)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void put_rec(logic [1:0] rtype, logic [7:0] bval, logic [2:0] cls,
			logic [3:0] kw, logic [31:0] num, logic [10:0] len, logic ovf);
		lex_record_t r;
		r = '{rtype, bval, cls, kw, num, len, ovf, 1'b0};
		if (step_recs.size() < 3)
			step_recs.push_back(r);
	endfunction

	function automatic void reset_token();
		lx_kw_live = '1;
		lx_len     = 0;
		lx_drop    = 1'b0;
		lx_acc     = '0;
		lx_neg     = 1'b0;
	endfunction

	function automatic void add_text(logic [7:0] c);
		if (lx_len < TOKEN_CAP) begin
			put_rec(REC_TEXT, c, '0, '0, '0, '0, 1'b0);
			lx_len++;
		end else begin
			lx_drop = 1'b1;
		end
	endfunction

	function automatic void add_ident_char(logic [7:0] c);
		for (int k = 0; k < 14; k++) begin
			if (lx_len >= kw_words[k].len() || kw_words[k][lx_len] != c)
				lx_kw_live[k] = 1'b0;
		end
		add_text(c);
	endfunction

	function automatic void finish_text(logic [2:0] cls);
		put_rec(REC_COMPLETE, '0, cls, '0, '0, 11'(lx_len), lx_drop);
	endfunction

	function automatic void finish_ident();
		for (int k = 0; k < 14; k++) begin
			if (!lx_drop && lx_kw_live[k] && kw_words[k].len() == lx_len) begin
				put_rec(REC_COMPLETE, '0, CLS_KEYWORD, 4'(k), '0, 11'(lx_len), 1'b0);
				return;
			end
		end
		finish_text(CLS_IDENT);
	endfunction

	function automatic void finish_number();
		put_rec(REC_COMPLETE, '0, CLS_NUMBER, '0, lx_neg ? -lx_acc : lx_acc, '0, 1'b0);
	endfunction

	function automatic void begin_digit(logic [7:0] c);
		lx_acc = '0;
		if (c == "0") begin
			lx_mode = M_ZERO;
		end else begin
			lx_acc  = 32'(c - 8'd48);
			lx_mode = M_DEC;
		end
	endfunction

	function automatic void between_tokens(logic [7:0] c, logic fin);
		lx_mode = M_IDLE;
		if (fin) begin
			put_rec(REC_END, '0, '0, '0, '0, '0, 1'b0);
			lx_single = 1'b0;
			reset_token();
		end else if (c > 8'd32 && c < 8'd128) begin
			reset_token();
			if (c == "#") begin
				lx_mode = M_COMMENT;
				put_rec(REC_COMMENT, c, '0, '0, '0, '0, 1'b0);
			end else if (is_letter(c)) begin
				lx_mode = M_IDENT;
				add_ident_char(c);
			end else if (c == "\"" || c == "'") begin
				lx_mode   = M_STRING;
				lx_single = (c == "'");
			end else if (is_digit(c)) begin
				begin_digit(c);
			end else if (c == "-") begin
				lx_neg  = 1'b1;
				lx_mode = M_MINUS;
			end else begin
				lx_mode = M_OPWORD;
				add_text(c);
			end
		end
	endfunction

	function automatic void lexer_reset();
		lx_mode   = M_IDLE;
		lx_single = 1'b0;
		reset_token();
	endfunction

	// records one accepted source byte gives rise to
	function automatic void tokenise_byte(logic [7:0] c_in, logic eot);
		logic [7:0]  c;
		logic        fin;
		logic [2:0]  qcls;
		lex_record_t r;
		c    = c_in;
		fin  = eot || (c == 8'h00);
		qcls = lx_single ? CLS_SQUOTE : CLS_DQUOTE;
		step_recs.delete();
		case (lx_mode)
			M_COMMENT: begin
				if (fin) begin
					put_rec(REC_COMMENT, 8'h0a, '0, '0, '0, '0, 1'b0);
					between_tokens(c, 1'b1);
				end else if (c == 8'h0a) begin
					put_rec(REC_COMMENT, 8'h0a, '0, '0, '0, '0, 1'b0);
					lx_mode = M_IDLE;
				end else begin
					put_rec(REC_COMMENT, c, '0, '0, '0, '0, 1'b0);
				end
			end
			M_IDENT: begin
				if (!fin && (is_letter(c) || is_digit(c))) begin
					add_ident_char(c);
				end else begin
					finish_ident();
					between_tokens(c, fin);
				end
			end
			M_STRING: begin
				if (fin) begin
					finish_text(qcls);
					between_tokens(c, 1'b1);
				end else if (c == (lx_single ? 8'h27 : 8'h22)) begin
					finish_text(qcls);
					lx_mode = M_IDLE;
				end else if (c == "\\") begin
					lx_mode = M_ESCAPE;
				end else begin
					add_text(c);
				end
			end
			M_ESCAPE: begin
				if (fin) begin
					add_text(8'h00);
					finish_text(qcls);
					between_tokens(c, 1'b1);
				end else begin
					if (c == "0")
						c = 8'd0;
					else if (c == "n")
						c = 8'd10;
					else if (c == "r")
						c = 8'd13;
					else if (c == "t")
						c = 8'd9;
					add_text(c);
					lx_mode = M_STRING;
				end
			end
			M_MINUS: begin
				if (!fin && is_digit(c)) begin
					begin_digit(c);
				end else if (!fin && c == ">") begin
					add_text("-");
					add_text(">");
					finish_text(CLS_OPWORD);
					lx_mode = M_IDLE;
				end else if (!fin && c > 8'd32 && c < 8'd128) begin
					add_text("-");
					add_text(c);
					lx_mode = M_OPWORD;
				end else begin
					add_text("-");
					finish_text(CLS_OPWORD);
					between_tokens(c, fin);
				end
			end
			M_ZERO, M_OCT: begin
				if (lx_mode == M_ZERO && !fin && c == "x") begin
					lx_mode = M_HEX;
				end else begin
					lx_mode = M_OCT;
					if (!fin && c >= "0" && c <= "7") begin
						lx_acc = lx_acc * 32'd8 + 32'(c - 8'd48);
					end else begin
						finish_number();
						between_tokens(c, fin);
					end
				end
			end
			M_DEC: begin
				if (!fin && is_digit(c)) begin
					lx_acc = lx_acc * 32'd10 + 32'(c - 8'd48);
				end else begin
					finish_number();
					between_tokens(c, fin);
				end
			end
			M_HEX: begin
				if (!fin && is_digit(c)) begin
					lx_acc = lx_acc * 32'd16 + 32'(c - 8'd48);
				end else if (!fin && c >= "a" && c <= "f") begin
					lx_acc = lx_acc * 32'd16 + 32'(c - 8'd87);
				end else if (!fin && c >= "A" && c <= "F") begin
					lx_acc = lx_acc * 32'd16 + 32'(c - 8'd55);
				end else begin
					finish_number();
					between_tokens(c, fin);
				end
			end
			M_OPWORD: begin
				if (!fin && c > 8'd32 && c < 8'd128) begin
					add_text(c);
				end else begin
					finish_text(CLS_OPWORD);
					between_tokens(c, fin);
				end
			end
			default: between_tokens(c, fin);
		endcase
		while (step_recs.size() > 0) begin
			r      = step_recs.pop_front();
			r.last = (step_recs.size() == 0);
			expected_records.push_back(r);
		end
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic eot);
		if (gaps_on && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eot;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tokenise_byte(c, eot);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	task automatic end_text();
		if ($urandom_range(1))
			send_byte(8'h00, 1'b0);
		else
			send_byte(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic flush_source();
		while (src_q.size() > 0)
			send_byte(src_q.pop_front(), 1'b0);
	endtask

	function automatic logic [7:0] pick(string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	function automatic void queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			src_q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] plain_byte(logic [7:0] avoid);
		logic [7:0] b;
		b = 8'($urandom_range(1, 255));
		return (b == avoid || b == "\\") ? "a" : b;
	endfunction

	// a well-formed token with random content, then up to three separator bytes
	function automatic void queue_random_token();
		logic [7:0] q;
		int         r;
		case ($urandom_range(11))
			0: queue_text(kw_words[$urandom_range(13)]);
			1: begin
				src_q.push_back(pick("abcxyzQRST_"));
				repeat ($urandom_range(7))
					src_q.push_back(pick("aeiouzAZ_0189"));
			end
			2: begin
				if ($urandom_range(1))
					src_q.push_back("-");
				src_q.push_back(8'($urandom_range(49, 57)));
				repeat ($urandom_range(11))
					src_q.push_back(pick("0123456789"));
			end
			3: begin
				if ($urandom_range(3) == 0)
					src_q.push_back("-");
				queue_text("0x");
				repeat ($urandom_range(9))
					src_q.push_back(pick("0123456789abcdefABCDEF"));
			end
			4: begin
				if ($urandom_range(1))
					src_q.push_back("-");
				src_q.push_back("0");
				repeat ($urandom_range(12))
					src_q.push_back(pick("012345677"));
			end
			5, 6: begin
				q = $urandom_range(1) ? 8'h27 : 8'h22;
				src_q.push_back(q);
				repeat ($urandom_range(8)) begin
					if ($urandom_range(4) == 0) begin
						src_q.push_back("\\");
						src_q.push_back(pick("0nrtq\\'\"7"));
					end else begin
						src_q.push_back(plain_byte(q));
					end
				end
				src_q.push_back(q);
			end
			7: begin
				src_q.push_back(pick("+*/<>=!&|%^~@$?:;.,()[]{}"));
				repeat ($urandom_range(2))
					src_q.push_back(8'($urandom_range(33, 127)));
			end
			8: queue_text("->");
			9: src_q.push_back("-");
			10: begin
				src_q.push_back("#");
				repeat ($urandom_range(10))
					src_q.push_back(plain_byte(8'h0a));
				src_q.push_back(8'h0a);
			end
			default: begin
				queue_text(kw_words[$urandom_range(13)]);
				src_q.push_back(pick("sx9_"));
			end
		endcase
		repeat ($urandom_range(3)) begin
			r = $urandom_range(5);
			if (r < 3)
				src_q.push_back(pick(" \t\n\015"));
			else if (r == 3)
				src_q.push_back(8'($urandom_range(128, 255)));
			else
				src_q.push_back(8'($urandom_range(1, 32)));
		end
	endfunction

	task automatic test_whitespace_and_comments();
		send_byte(8'd1, 1'b0);
		send_byte(8'd32, 1'b0);
		send_byte(8'd128, 1'b0);
		send_byte(8'd255, 1'b0);
		send_text("# note\n");
		send_text("#x");
		send_byte(8'h00, 1'b0);
	endtask

	task automatic test_words();
		send_text("func const var loop break continue then else and or ret pop dup goto ");
		send_text("fun funcs Or _a9 o");
		send_byte(8'hA5, 1'b1);
	endtask

	task automatic test_numbers();
		send_text("0 2147483647 4294967297 -12 0x 0xFfA0 0X1 017 08 -0x10 99999999999-");
		send_byte(8'h00, 1'b0);
	endtask

	task automatic test_quotes();
		send_text("\"a\\0\\n\\r\\t\\q\\\"\" 'x\\'y' '' ");
		send_text("'abc");
		send_byte(8'hFF, 1'b1);
		send_text("\"z\\");
		send_byte(8'h00, 1'b0);
	endtask

	task automatic test_operators();
		send_text("-> -+ + <= -\t- a-1 -");
		send_byte(8'h80, 1'b0);
		send_text("->");
		send_byte(8'h5C, 1'b1);
	endtask

	task automatic test_capacity();
		send_byte("v", 1'b0);
		for (int i = 0; i < TOKEN_CAP + 5; i++)
			send_byte(8'($urandom_range(97, 122)), 1'b0);
		send_text(" '");
		for (int i = 0; i < TOKEN_CAP + 1; i++)
			send_byte(i == TOKEN_CAP - 1 ? 8'h5C : 8'($urandom_range(48, 57)), 1'b0);
		send_text("' ");
		end_text();
	endtask

	task automatic test_output_stall();
		hold_go = 1'b1;
		send_text("loop dup 0x7fffffff -> pop ret # held\n 'ab\\tc' goto =>= ");
		end_text();
	endtask

	task automatic test_random_tokens(input int count);
		int start;
		int r;
		start = bytes_sent;
		while (bytes_sent - start < count) begin
			r = $urandom_range(99);
			if (r < 10) begin
				send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
			end else if (r < 14) begin
				end_text();
			end else begin
				queue_random_token();
				flush_source();
			end
		end
		end_text();
	endtask

	always @(posedge clk) begin : rx_side
		lex_record_t want;
		if (m_tvalid && m_tready) begin
			records_checked++;
			if (m_tuser == REC_COMPLETE)
				tokens_seen++;
			if (m_tuser == REC_END)
				ends_seen++;
			if (expected_records.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected transfer: type %0d data %016h last %0d",
						m_tuser, m_tdata, m_tlast);
			end else begin
				want = expected_records.pop_front();
				if (m_tuser !== want.rtype || m_tdata[7:0] !== want.bval
						|| m_tdata[10:8] !== want.cls || m_tdata[14:11] !== want.kw
						|| m_tdata[46:15] !== want.num || m_tdata[57:47] !== want.len
						|| m_tdata[58] !== want.ovf || m_tdata[63:59] !== 5'd0
						|| m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN) begin
						$write("mismatch exp: type %0d byte %02h cls %0d kw %0d",
							want.rtype, want.bval, want.cls, want.kw);
						$display(" num %08h len %0d ovf %0d last %0d",
							want.num, want.len, want.ovf, want.last);
						$write("         got: type %0d byte %02h cls %0d kw %0d",
							m_tuser, m_tdata[7:0], m_tdata[10:8], m_tdata[14:11]);
						$display(" num %08h len %0d ovf %0d last %0d pad %0h",
							m_tdata[46:15], m_tdata[57:47], m_tdata[58], m_tlast,
							m_tdata[63:59]);
					end
				end
			end
		end
		m_tready <= !rx_hold && (!gaps_on || $urandom_range(99) >= 13);
	end

	// long receiver hold-off so the record buffer fills and stalls the input
	initial forever begin
		@(posedge clk);
		if (hold_go) begin
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
			hold_go = 1'b0;
		end
	end

	initial begin
		#5_000_000;
		$display("stack_language_tokenizer regression: fail");
		$finish;
	end

	initial begin
		lexer_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_whitespace_and_comments();
		test_words();
		test_numbers();
		test_quotes();
		test_operators();
		test_output_stall();
		test_capacity();
		test_random_tokens(RANDOM_ITEMS * 2 / 3);
		gaps_on = 1'b0;
		test_random_tokens(RANDOM_ITEMS / 3);
		gaps_on = 1'b1;
		s_tvalid <= 1'b0;
		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("sent %0d source bytes; checked %0d records, %0d tokens, %0d text ends",
			bytes_sent, records_checked, tokens_seen, ends_seen);
		$display("covered comments, keywords, number bases, quotes, overflow, stalls");
		if (mismatches == 0 && expected_records.size() == 0)
			$display("stack_language_tokenizer regression: pass");
		else
			$display("stack_language_tokenizer regression: fail");
		$finish;
	end

endmodule
